@@ src/fnpc_pkg.sv @@
// ----------------------------------------------------------------------------
// fnpc_pkg: shared types and tables for the name pack codec
// Symbol table of the 48-symbol prefix code, command codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fnpc_pkg;

  localparam int SymCount = 48;
  localparam int NameBits = 28;
  localparam int MaxChars = 7;

  // Symbol table, index 0..47
  localparam logic [7:0] SYM_TABLE [SymCount] = '{
    8'h20, "r", "t", "o", "e", "a", "n", "i",
    "s", "m", "c", "y", "l", "g", "f", "w",
    "d", "v", "p", "b", "h", "x", "u", "q",
    "0", "1", "2", "3", "4", "5", "6", "7",
    "8", "9", "j", "-", "k", ".", "z", "/",
    ";", ":", "!", "+", "@", "*", ",", "?"
  };

  // Code length classes
  localparam logic [2:0] LEN_SHORT = 3'd4;
  localparam logic [2:0] LEN_MID   = 3'd5;
  localparam logic [2:0] LEN_LONG  = 3'd7;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_DECODE = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic enc_step;   // absorb one character
    logic dec_load;   // load a packed word
    logic dec_step;   // emit one decoded character
  } fnpc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic word_zero;  // incoming packed word has no code bits
    logic dec_final;  // current decode step yields the last character
  } fnpc_stat_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
  } sym_lookup_t;

  // Reverse lookup: character to symbol index
  function automatic sym_lookup_t sym_find(input logic [7:0] ch);
    sym_lookup_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int k = 0; k < SymCount; k++) begin
      if (SYM_TABLE[k] == ch) begin
        r.hit = 1'b1;
        r.idx = 6'(k);
      end
    end
    return r;
  endfunction

  // Forward lookup: symbol index to character
  function automatic logic [7:0] sym_char(input logic [5:0] sym);
    logic [7:0] c;
    c = 8'h00;
    for (int k = 0; k < SymCount; k++) begin
      if (sym == 6'(k)) c = SYM_TABLE[k];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/fnpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fnpc_ctrl: controller of the name pack codec
// Takes input transfers while idle and steps the decoder one character
// per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fnpc_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_cmd,
  output logic                 in_ready,
  input  fnpc_pkg::fnpc_stat_t stat,
  output fnpc_pkg::fnpc_cmd_t  cmd
);

  fnpc_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fnpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.enc_step = 1'b0;
    cmd.dec_load = 1'b0;
    cmd.dec_step = 1'b0;
    case (state)
      fnpc_pkg::ST_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          if (in_cmd == fnpc_pkg::CMD_ENCODE) begin
            cmd.enc_step = 1'b1;
          end else begin
            cmd.dec_load = 1'b1;
            if (!stat.word_zero) state_next = fnpc_pkg::ST_DECODE;
          end
        end
      end
      fnpc_pkg::ST_DECODE: begin
        if (stat.out_free) begin
          cmd.dec_step = 1'b1;
          if (stat.dec_final) state_next = fnpc_pkg::ST_IDLE;
        end
      end
      default: state_next = fnpc_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ src/fnpc_dp.sv @@
// ----------------------------------------------------------------------------
// fnpc_dp: datapath of the name pack codec
// Encode accumulator, decode shift register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fnpc_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  fnpc_pkg::fnpc_cmd_t  cmd,
  output fnpc_pkg::fnpc_stat_t stat,
  input  wire  [7:0]           in_char,
  input  wire                  in_last,
  input  wire  [31:0]          in_word,
  input  wire                  out_ready,
  output logic                 out_valid,
  output logic [31:0]          packed_out,
  output logic [7:0]           char_out,
  output logic                 is_char,
  output logic                 last,
  output logic                 bad_char,
  output logic                 truncated
);

  // Encode state
  logic [27:0] acc, acc_next;
  logic [4:0]  rem, rem_next;
  logic        bad_flag, bad_next;
  logic        trunc_flag, trunc_next;

  // Decode state
  logic [31:0] coded, coded_next;
  logic [2:0]  count;

  fnpc_pkg::sym_lookup_t look;
  logic [2:0]  enc_len;
  logic [27:0] packed_name;

  logic [3:0]  nib;
  logic [5:0]  dec_sym;
  logic [2:0]  dec_len;
  logic        out_load;

  // Encode: code one character and append it if it fits
  always_comb begin
    look       = fnpc_pkg::sym_find(in_char);
    acc_next   = acc;
    rem_next   = rem;
    bad_next   = bad_flag;
    trunc_next = trunc_flag;
    if (look.idx > 6'd15) begin
      enc_len = fnpc_pkg::LEN_LONG;
    end else if (look.idx > 6'd7) begin
      enc_len = fnpc_pkg::LEN_MID;
    end else begin
      enc_len = fnpc_pkg::LEN_SHORT;
    end
    if (!look.hit) begin
      bad_next = 1'b1;
    end else if (trunc_flag || ({2'b00, enc_len} > rem)) begin
      trunc_next = 1'b1;
    end else begin
      rem_next = rem - {2'b00, enc_len};
      case (enc_len)
        fnpc_pkg::LEN_SHORT: acc_next = {acc[23:0], look.idx[3:0]};
        fnpc_pkg::LEN_MID:   acc_next = {acc[22:0], 2'b10, look.idx[2:0]};
        default:             acc_next = {acc[20:0], 2'b11, look.idx[4:0] - 5'd16};
      endcase
    end
    packed_name = acc_next << rem_next;
  end

  // Decode: one symbol from the top of the shift register
  always_comb begin
    nib = coded[31:28];
    if (!nib[3]) begin
      dec_sym = {3'b000, nib[2:0]};
      dec_len = fnpc_pkg::LEN_SHORT;
    end else if (!nib[2]) begin
      dec_sym = {3'b001, nib[1:0], coded[27]};
      dec_len = fnpc_pkg::LEN_MID;
    end else begin
      dec_sym = {3'(nib - 4'd10), coded[27:25]};
      dec_len = fnpc_pkg::LEN_LONG;
    end
    coded_next = coded << dec_len;
  end

  // Status to the controller
  always_comb begin
    stat.out_free  = !out_valid || out_ready;
    stat.word_zero = (in_word[31:4] == 28'd0);
    stat.dec_final = (coded_next == 32'd0) || (count == 3'(fnpc_pkg::MaxChars - 1));
  end

  assign out_load = (cmd.enc_step && in_last) || (cmd.dec_load && stat.word_zero)
                    || cmd.dec_step;

  // Encode state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      rem        <= 5'(fnpc_pkg::NameBits);
      bad_flag   <= 1'b0;
      trunc_flag <= 1'b0;
    end else if (cmd.enc_step) begin
      if (in_last) begin
        acc        <= '0;
        rem        <= 5'(fnpc_pkg::NameBits);
        bad_flag   <= 1'b0;
        trunc_flag <= 1'b0;
      end else begin
        acc        <= acc_next;
        rem        <= rem_next;
        bad_flag   <= bad_next;
        trunc_flag <= trunc_next;
      end
    end
  end

  // Decode shift register and character count
  always_ff @(posedge clk) begin
    if (cmd.dec_load) begin
      coded <= {in_word[31:4], 4'b0000};
      count <= '0;
    end else if (cmd.dec_step) begin
      coded <= coded_next;
      count <= count + 3'd1;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      packed_out <= '0;
      char_out   <= '0;
      is_char    <= 1'b0;
      last       <= 1'b1;
      bad_char   <= 1'b0;
      truncated  <= 1'b0;
      if (cmd.enc_step) begin
        packed_out <= {packed_name, 4'b0000};
        bad_char   <= bad_next;
        truncated  <= trunc_next;
      end else if (cmd.dec_step) begin
        char_out <= fnpc_pkg::sym_char(dec_sym);
        is_char  <= 1'b1;
        last     <= stat.dec_final;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/forth_name_pack_codec_top.sv @@
// ----------------------------------------------------------------------------
// forth_name_pack_codec_top: word name pack/unpack codec
// Packs names into 28 code bits with the 48-symbol prefix code and unpacks
// packed words back into characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser selects encode (0) or decode (1). An encode transfer
//   carries one character in tdata[7:0], tlast on the final character of the
//   name. A decode transfer carries the packed word in tdata[39:8].
//   Encode takes one character per cycle while the output register is free;
//   the packed word (with bad_char and truncated flags) is registered when the
//   final character is taken. Decode: a word with no code bits (tdata[39:12]
//   zero) gives one empty result the next cycle. Otherwise the word is loaded
//   into the decode shift register, which then emits one character per cycle
//   while the output is free, up to seven, tlast on the final one; the input
//   channel is held until the last character is emitted.
//   A single output register parts the channels: the next input is taken
//   when that register is empty or its result is taken in the same cycle.
//   Reset clears the pending name, flags, controller state and output valid.
//   When the receiver stalls, the result holds and input is back-pressured.
// ----------------------------------------------------------------------------
`default_nettype none

module forth_name_pack_codec_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // char_code[7:0], packed_word[39:8]
  input  wire         s_axis_tlast,
  input  wire         s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // packed_out[31:0], char_out[39:32],
                                      // bad_char[40], truncated[41], zero
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // is_char
);

  fnpc_pkg::fnpc_cmd_t  cmd;
  fnpc_pkg::fnpc_stat_t stat;

  logic [31:0] packed_out;
  logic [7:0]  char_out;
  logic        bad_char;
  logic        truncated;

  fnpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fnpc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_char    (s_axis_tdata[7:0]),
    .in_last    (s_axis_tlast),
    .in_word    (s_axis_tdata[39:8]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .packed_out (packed_out),
    .char_out   (char_out),
    .is_char    (m_axis_tuser),
    .last       (m_axis_tlast),
    .bad_char   (bad_char),
    .truncated  (truncated)
  );

  // Result packing
  assign m_axis_tdata = {6'b000000, truncated, bad_char, char_out, packed_out};

endmodule

`default_nettype wire
